>>> rtl/core/sks_pkg.sv
// shared types and constants for the sorted key set
package sks_pkg;
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FUNC_CONTAINS = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_REMOVE   = 2'd2,
    FUNC_RSVD     = 2'd3
  } func_t;

  typedef struct packed {
    logic load;
    logic commit;
  } sks_cmd_t;

  typedef struct packed {
    logic dummy;
  } sks_stat_t;
endpackage

>>> rtl/core/sks_req_if.sv
// request channel interface
interface sks_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] key;
  modport source (output valid, func, key, input ready);
  modport sink (input valid, func, key, output ready);
endinterface

>>> rtl/core/sks_rsp_if.sv
// response channel interface
interface sks_rsp_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic [6:0] position;
  logic       overflow;
  logic [6:0] occupancy;
  modport source (output valid, success, position, overflow, occupancy, input ready);
  modport sink (input valid, success, position, overflow, occupancy, output ready);
endinterface

>>> rtl/core/sks_ctrl.sv
// request sequencer: load, commit, hold result
module sks_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sks_pkg::sks_cmd_t cmd
);
  import sks_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_DONE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == ST_EXEC);

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.commit) else $error("load not followed by commit");
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("commit not followed by result");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while result pending");
endmodule

>>> rtl/core/sks_dpath.sv
// cell array of keys: parallel compare and shift
module sks_dpath (
  input  logic                     clk,
  input  logic                     rst,
  input  sks_pkg::sks_cmd_t        cmd,
  input  logic [1:0]               func,
  input  logic [31:0]              key,
  output logic                     success,
  output logic [6:0]               position,
  output logic                     overflow,
  output logic [6:0]               occupancy
);
  import sks_pkg::*;

  logic [KEY_BITS-1:0] keys [CAPACITY];
  logic [CNT_BITS-1:0] count;
  logic [1:0]          r_func;
  logic [KEY_BITS-1:0] r_key;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CNT_BITS-1:0] pos;
  logic                found;
  logic                do_add;
  logic                do_rem;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func;
      r_key  <= key[KEY_BITS-1:0];
    end
  end

  // each cell compares against the key; valid cells below count only
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_vec[i] = (CNT_BITS'(i) < count) && (keys[i] < r_key);
      eq_vec[i] = (CNT_BITS'(i) < count) && (keys[i] == r_key);
    end
  end

  assign pos    = CNT_BITS'($countones(lt_vec));
  assign found  = |eq_vec;
  assign do_add = (func_t'(r_func) == FUNC_ADD) && !found &&
                  (count != CNT_BITS'(CAPACITY));
  assign do_rem = (func_t'(r_func) == FUNC_REMOVE) && found;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_add) begin
          if (CNT_BITS'(i) == pos) keys[i] <= r_key;
          else if (CNT_BITS'(i) > pos && i > 0) keys[i] <= keys[(i > 0) ? i - 1 : 0];
        end else if (do_rem) begin
          if (CNT_BITS'(i) >= pos && i < CAPACITY - 1)
            keys[i] <= keys[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.commit) begin
      if (do_add) count <= count + 1'b1;
      else if (do_rem) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      success  <= do_add || do_rem ||
                  ((func_t'(r_func) != FUNC_ADD) && (func_t'(r_func) != FUNC_REMOVE) && found);
      position <= 7'(pos);
      overflow <= (func_t'(r_func) == FUNC_ADD) && !found && (count == CNT_BITS'(CAPACITY));
    end
  end

  assign occupancy = 7'(count);

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY)) else $error("count above capacity");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count)) else $error("count moved without commit");
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_add |=> success && !overflow) else $error("insert flagged as refused");
endmodule

>>> rtl/core/sorted_key_set_top.sv
// top level of the sorted key set
// channel | dir | fields
// req     | in  | func, key
// rsp     | out | success, position, overflow, occupancy
// each request passes through accept, parallel compare and shift in the
// cell array, and result hold; the next request enters once the result transfers.
// rst (synchronous) empties the set; stored keys are not cleared.
// a stalled result holds the block, no request is taken meanwhile.
module sorted_key_set_top (
  input logic    clk,
  input logic    rst,
  sks_req_if.sink   req,
  sks_rsp_if.source rsp
);
  import sks_pkg::*;

  sks_cmd_t cmd;

  sks_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(cmd)
  );

  sks_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .func(req.func), .key(req.key),
    .success(rsp.success), .position(rsp.position),
    .overflow(rsp.overflow), .occupancy(rsp.occupancy)
  );
endmodule
